// ----- rtl/mlfq_pkg.sv -----
`default_nettype none
package mlfq_pkg;

   localparam int NUM_LEVELS = 3;
   localparam int LEVEL_W    = 2;
   localparam int SLICE_W    = 8;
   localparam int IN_SLOT_W  = 4;
   localparam int BURST_W    = 10;
   localparam int OUT_TIME_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICE0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE2 = 2'd2;

   localparam logic [SLICE_W-1:0] SLICE0_RESET = 8'd2;
   localparam logic [SLICE_W-1:0] SLICE1_RESET = 8'd4;
   localparam logic [SLICE_W-1:0] SLICE2_RESET = 8'd8;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP    = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID    = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM = 2'd2;

   typedef logic [NUM_LEVELS-1:0][SLICE_W-1:0] slices_type;

   typedef struct packed {
      logic                 is_tick;
      logic [IN_SLOT_W-1:0] slot;
      logic [BURST_W-1:0]   burst;
   } item_type;

   typedef struct packed {
      logic                  busy;
      logic [IN_SLOT_W-1:0]  run_slot;
      logic [LEVEL_W-1:0]    run_level;
      logic                  done;
      logic [IN_SLOT_W-1:0]  done_slot;
      logic [OUT_TIME_W-1:0] turnaround;
      logic [OUT_TIME_W-1:0] waiting;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQUEUE,
      ST_DISPATCH,
      ST_LOAD,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/mlfq_front.sv -----
`default_nettype none
module mlfq_front
   import mlfq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_opcode,
   input  wire logic [IN_SLOT_W-1:0] req_proc_slot,
   input  wire logic [BURST_W-1:0]   req_burst_len,
   output logic                      item_valid,
   output item_type                  item,
   input  wire logic                 item_pop
);

   // two-entry queue between accept and execution
   item_type   entry_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      entry_in.is_tick = (req_opcode == OP_TICK);
      entry_in.slot    = req_proc_slot;
      entry_in.burst   = req_burst_len;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mlfq_back.sv -----
`default_nettype none
module mlfq_back
   import mlfq_pkg::*;
#(
   parameter int PROC_SLOTS = 16,
   parameter int TIME_BITS  = 16
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire slices_type slices,
   input  wire logic       item_valid,
   input  wire item_type   item,
   output logic            item_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp
);

   localparam int SLOT_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
   localparam int CNT_W  = $clog2(PROC_SLOTS + 1);
   localparam int DEPTH  = NUM_LEVELS * PROC_SLOTS;
   localparam int ADDR_W = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      cnt_ff  [NUM_LEVELS];
   logic [CNT_W-1:0]      cnt_in  [NUM_LEVELS];
   logic [SLOT_W-1:0]     head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0]     head_in [NUM_LEVELS];
   logic [PROC_SLOTS-1:0] active_ff, active_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [LEVEL_W-1:0]    cur_level_ff, cur_level_in;
   logic [SLICE_W-1:0]    slice_ff, slice_in;
   logic                  requeue_ff, requeue_in;
   logic                  disp_ff, disp_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   // level queues share one memory, one region per level
   logic [SLOT_W-1:0]    fifo_mem [DEPTH];
   logic [SLOT_W-1:0]    fifo_rd_ff;
   logic                 fifo_we;
   logic [ADDR_W-1:0]    fifo_waddr;
   logic [SLOT_W-1:0]    fifo_wdata;
   logic [ADDR_W-1:0]    fifo_raddr;

   // per-slot tables
   logic [BURST_W-1:0]   rem_mem   [PROC_SLOTS];
   logic [BURST_W-1:0]   burst_mem [PROC_SLOTS];
   logic [TIME_BITS-1:0] stamp_mem [PROC_SLOTS];
   logic [BURST_W-1:0]   rem_rd_ff;
   logic [BURST_W-1:0]   burst_rd_ff;
   logic [TIME_BITS-1:0] stamp_rd_ff;
   logic                 rem_we;
   logic                 arr_we;
   logic [SLOT_W-1:0]    tbl_waddr;
   logic [BURST_W-1:0]   rem_wdata;
   logic [SLOT_W-1:0]    tbl_raddr;

   logic [8:0]           in_slot_ext;
   logic [SLOT_W-1:0]    in_slot;
   logic                 in_ok;
   logic                 exec_fire;
   logic [SLOT_W-1:0]    load_slot;
   logic [BURST_W-1:0]   rem_next;
   logic [SLICE_W-1:0]   slice_next;
   logic [TIME_BITS-1:0] time_next;
   logic [TIME_BITS-1:0] ta_time;
   logic [31:0]          ta_ext;
   logic [OUT_TIME_W-1:0] ta16;
   logic [LEVEL_W-1:0]   down_level;
   logic [8:0]           cur_slot_ext;

   function automatic logic [ADDR_W-1:0] tail_addr(
      input logic [LEVEL_W-1:0] lvl,
      input logic [SLOT_W-1:0]  head,
      input logic [CNT_W-1:0]   cnt
   );
      logic [CNT_W:0]    sum;
      logic [ADDR_W+8:0] base;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
      if (sum >= (CNT_W+1)'(PROC_SLOTS)) begin
         sum = sum - (CNT_W+1)'(PROC_SLOTS);
      end
      base = (ADDR_W+9)'(lvl) * (ADDR_W+9)'(PROC_SLOTS) + (ADDR_W+9)'(sum);
      return base[ADDR_W-1:0];
   endfunction

   assign in_slot_ext  = {5'd0, item.slot};
   assign in_slot      = in_slot_ext[SLOT_W-1:0];
   assign in_ok        = (in_slot_ext < 9'(PROC_SLOTS)) && (item.burst != '0)
                         && !active_ff[in_slot];
   assign exec_fire    = !rsp_valid_ff || rsp_ready;
   assign load_slot    = disp_ff ? fifo_rd_ff : cur_slot_ff;
   assign rem_next     = (rem_rd_ff != '0) ? rem_rd_ff - 1'b1 : rem_rd_ff;
   assign slice_next   = (slice_ff != '0) ? slice_ff - 1'b1 : slice_ff;
   assign time_next    = time_ff + 1'b1;
   // turnaround wraps at the time counter width
   assign ta_time      = time_next - stamp_rd_ff;
   assign ta_ext       = 32'(ta_time);
   assign ta16         = ta_ext[OUT_TIME_W-1:0];
   assign down_level   = (cur_level_ff == LEVEL_TOP) ? LEVEL_MID : LEVEL_BOTTOM;
   assign cur_slot_ext = 9'(cur_slot_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && item.is_tick) begin
               state_in = ST_REQUEUE;
            end
         end
         ST_REQUEUE:  state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = ST_LOAD;
         ST_LOAD:     state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic found;
      found        = 1'b0;
      item_pop     = 1'b0;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      active_in    = active_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      cur_level_in = cur_level_ff;
      slice_in     = slice_ff;
      requeue_in   = requeue_ff;
      disp_in      = disp_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      fifo_we      = 1'b0;
      fifo_waddr   = '0;
      fifo_wdata   = cur_slot_ff;
      fifo_raddr   = '0;
      rem_we       = 1'b0;
      arr_we       = 1'b0;
      tbl_waddr    = cur_slot_ff;
      rem_wdata    = rem_next;
      tbl_raddr    = cur_slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            item_pop = item_valid;
            if (item_valid && !item.is_tick && in_ok) begin
               active_in[in_slot] = 1'b1;
               arr_we     = 1'b1;
               tbl_waddr  = in_slot;
               fifo_we    = 1'b1;
               fifo_wdata = in_slot;
               fifo_waddr = tail_addr(LEVEL_TOP, head_ff[0], cnt_ff[0]);
               cnt_in[0]  = cnt_ff[0] + 1'b1;
            end
         end
         ST_REQUEUE: begin
            if (requeue_ff) begin
               fifo_we    = 1'b1;
               fifo_waddr = tail_addr(down_level, head_ff[down_level],
                                      cnt_ff[down_level]);
               cnt_in[down_level] = cnt_ff[down_level] + 1'b1;
               requeue_in   = 1'b0;
               cur_valid_in = 1'b0;
            end
         end
         ST_DISPATCH: begin
            disp_in = 1'b0;
            if (!cur_valid_ff) begin
               for (int l = 0; l < NUM_LEVELS; l++) begin
                  if (!found && cnt_ff[l] != '0) begin
                     found        = 1'b1;
                     fifo_raddr   = tail_addr(LEVEL_W'(l), head_ff[l], '0);
                     head_in[l]   = (head_ff[l] == SLOT_W'(PROC_SLOTS - 1)) ?
                                    '0 : head_ff[l] + 1'b1;
                     cnt_in[l]    = cnt_ff[l] - 1'b1;
                     cur_level_in = LEVEL_W'(l);
                     cur_valid_in = 1'b1;
                     disp_in      = 1'b1;
                     slice_in     = (slices[l] != '0) ? slices[l] : 8'd1;
                  end
               end
            end
         end
         ST_LOAD: begin
            cur_slot_in = load_slot;
            tbl_raddr   = load_slot;
         end
         ST_EXEC: begin
            if (exec_fire) begin
               time_in      = time_next;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (cur_valid_ff) begin
                  rsp_in.busy      = 1'b1;
                  rsp_in.run_slot  = cur_slot_ext[IN_SLOT_W-1:0];
                  rsp_in.run_level = cur_level_ff;
                  rem_we           = 1'b1;
                  slice_in         = slice_next;
                  if (rem_next == '0) begin
                     rsp_in.done       = 1'b1;
                     rsp_in.done_slot  = cur_slot_ext[IN_SLOT_W-1:0];
                     rsp_in.turnaround = ta16;
                     rsp_in.waiting    = ta16 - OUT_TIME_W'(burst_rd_ff);
                     active_in[cur_slot_ff] = 1'b0;
                     cur_valid_in      = 1'b0;
                  end else if (slice_next == '0) begin
                     requeue_in = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
      fifo_rd_ff <= fifo_mem[fifo_raddr];
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[tbl_waddr] <= rem_wdata;
      end else if (arr_we) begin
         rem_mem[tbl_waddr] <= item.burst;
      end
      rem_rd_ff <= rem_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (arr_we) begin
         burst_mem[tbl_waddr] <= item.burst;
         stamp_mem[tbl_waddr] <= time_ff;
      end
      burst_rd_ff <= burst_mem[tbl_raddr];
      stamp_rd_ff <= stamp_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '{default: '0};
         head_ff      <= '{default: '0};
         active_ff    <= '0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         cur_level_ff <= '0;
         slice_ff     <= '0;
         requeue_ff   <= 1'b0;
         disp_ff      <= 1'b0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         active_ff    <= active_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         cur_level_ff <= cur_level_in;
         slice_ff     <= slice_in;
         requeue_ff   <= requeue_in;
         disp_ff      <= disp_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/multilevel_feedback_queue_scheduler_unit.sv -----
// arrive transaction: handled in the idle state of the execution unit after the input queue
// tick transaction: requeue write, dispatch, fifo read, table read, execute
// the sequencer runs one item at a time
// a 2-entry input queue and an output register decouple both channels
// reset: synchronous, active high; queues empty, slots inactive, slices 2/4/8
`default_nettype none
module multilevel_feedback_queue_scheduler_unit
   import mlfq_pkg::*;
#(
   parameter int PROC_SLOTS = 16,
   parameter int TIME_BITS  = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [IN_SLOT_W-1:0]  req_proc_slot,
   input  wire logic [BURST_W-1:0]    req_burst_len,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_busy_res,
   output logic [IN_SLOT_W-1:0]       rsp_run_slot,
   output logic [LEVEL_W-1:0]         rsp_run_level,
   output logic                       rsp_done_res,
   output logic [IN_SLOT_W-1:0]       rsp_done_slot,
   output logic [OUT_TIME_W-1:0]      rsp_turnaround,
   output logic [OUT_TIME_W-1:0]      rsp_waiting,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SLICE_W-1:0]    csr_data
);

   slices_type slices_ff, slices_in;
   logic       item_valid;
   item_type   item;
   logic       item_pop;
   result_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      slices_in = slices_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLICE0: slices_in[0] = csr_data;
            CSR_SLICE1: slices_in[1] = csr_data;
            CSR_SLICE2: slices_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= {SLICE2_RESET, SLICE1_RESET, SLICE0_RESET};
      end else begin
         slices_ff <= slices_in;
      end
   end

   mlfq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_proc_slot (req_proc_slot),
      .req_burst_len (req_burst_len),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   mlfq_back #(
      .PROC_SLOTS (PROC_SLOTS),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .slices     (slices_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_busy_res   = rsp.busy;
   assign rsp_run_slot   = rsp.run_slot;
   assign rsp_run_level  = rsp.run_level;
   assign rsp_done_res   = rsp.done;
   assign rsp_done_slot  = rsp.done_slot;
   assign rsp_turnaround = rsp.turnaround;
   assign rsp_waiting    = rsp.waiting;

endmodule
`default_nettype wire

// ----- rtl/mlfq_checker.sv -----
`default_nettype none
module mlfq_checker
   import mlfq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_busy_res,
   input wire logic [IN_SLOT_W-1:0]  rsp_run_slot,
   input wire logic [LEVEL_W-1:0]    rsp_run_level,
   input wire logic                  rsp_done_res,
   input wire logic [IN_SLOT_W-1:0]  rsp_done_slot,
   input wire logic [OUT_TIME_W-1:0] rsp_turnaround,
   input wire logic [OUT_TIME_W-1:0] rsp_waiting
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_done_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res && rsp_done_slot == rsp_run_slot)
      else $error("finished slot differs from running slot");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_run_slot == '0 && rsp_run_level == '0)
      else $error("idle tick carries a slot");

   a_no_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_turnaround == '0 && rsp_waiting == '0 && rsp_done_slot == '0)
      else $error("times reported without completion");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_level != 2'd3)
      else $error("level out of range");

endmodule

bind multilevel_feedback_queue_scheduler_unit mlfq_checker u_mlfq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_run_slot   (rsp_run_slot),
   .rsp_run_level  (rsp_run_level),
   .rsp_done_res   (rsp_done_res),
   .rsp_done_slot  (rsp_done_slot),
   .rsp_turnaround (rsp_turnaround),
   .rsp_waiting    (rsp_waiting)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import mlfq_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CSR_IDX_MAX    = 3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_opcode = OP_ARRIVE;
   logic [IN_SLOT_W-1:0]  req_proc_slot = '0;
   logic [BURST_W-1:0]    req_burst_len = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_busy_res;
   logic [IN_SLOT_W-1:0]  rsp_run_slot;
   logic [LEVEL_W-1:0]    rsp_run_level;
   logic                  rsp_done_res;
   logic [IN_SLOT_W-1:0]  rsp_done_slot;
   logic [OUT_TIME_W-1:0] rsp_turnaround;
   logic [OUT_TIME_W-1:0] rsp_waiting;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [SLICE_W-1:0]    csr_data = '0;

   always #2 clock = ~clock;

   multilevel_feedback_queue_scheduler_unit u_top (.*);

   // scheduler shadow state
   slices_type             slice_len;
   logic [IN_SLOT_W-1:0]   ready_q [NUM_LEVELS][$];
   logic [BURST_W-1:0]     left_time [16];
   logic [BURST_W-1:0]     total_len [16];
   logic [OUT_TIME_W-1:0]  arrive_time [16];
   logic [15:0]            active_mask;
   logic [IN_SLOT_W-1:0]   cpu_slot;
   logic                   cpu_valid;
   logic [LEVEL_W-1:0]     cpu_level;
   logic [SLICE_W-1:0]     cpu_slice;
   logic                   demote_pending;
   logic [OUT_TIME_W-1:0]  now;

   result_type sched_expected [$];
   int  mismatches = 0;
   int  unexpected = 0;
   int  items_sent = 0;
   int  ticks_seen = 0;
   int  done_seen  = 0;
   int  idle_cycles = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;
   bit  hold_rsp  = 1'b0;

   task automatic shadow_reset();
      slice_len = {SLICE2_RESET, SLICE1_RESET, SLICE0_RESET};
      for (int l = 0; l < NUM_LEVELS; l++) ready_q[l].delete();
      active_mask = '0;
      cpu_slot = '0; cpu_valid = 1'b0; cpu_level = '0; cpu_slice = '0;
      demote_pending = 1'b0; now = '0;
   endtask

   task automatic schedule_step(input logic op, input logic [IN_SLOT_W-1:0] slot,
                                input logic [BURST_W-1:0] burst);
      result_type r;
      logic [LEVEL_W-1:0] nxt;
      logic [OUT_TIME_W-1:0] ta;
      r = '0;
      if (op == OP_ARRIVE) begin
         if (burst != 0 && !active_mask[slot]) begin
            active_mask[slot] = 1'b1;
            left_time[slot] = burst;
            total_len[slot] = burst;
            arrive_time[slot] = now;
            ready_q[LEVEL_TOP] = {ready_q[LEVEL_TOP], slot};
         end
         return;
      end
      if (demote_pending) begin
         nxt = (cpu_level == LEVEL_BOTTOM) ? LEVEL_BOTTOM : cpu_level + 1'b1;
         ready_q[nxt] = {ready_q[nxt], cpu_slot};
         demote_pending = 1'b0;
         cpu_valid = 1'b0;
      end
      if (!cpu_valid) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (!cpu_valid && ready_q[l].size() != 0) begin
               cpu_slot = ready_q[l].pop_front();
               cpu_level = l[LEVEL_W-1:0];
               cpu_valid = 1'b1;
               cpu_slice = (slice_len[l] != 0) ? slice_len[l] : 8'd1;
            end
         end
      end
      now = now + 1'b1;
      if (cpu_valid) begin
         r.busy = 1'b1;
         r.run_slot = cpu_slot;
         r.run_level = cpu_level;
         if (left_time[cpu_slot] != 0) left_time[cpu_slot]--;
         if (cpu_slice != 0) cpu_slice--;
         if (left_time[cpu_slot] == 0) begin
            ta = now - arrive_time[cpu_slot];
            r.done = 1'b1;
            r.done_slot = cpu_slot;
            r.turnaround = ta;
            r.waiting = ta - OUT_TIME_W'(total_len[cpu_slot]);
            active_mask[cpu_slot] = 1'b0;
            cpu_valid = 1'b0;
         end else if (cpu_slice == 0) begin
            demote_pending = 1'b1;
         end
      end
      sched_expected = {sched_expected, r};
   endtask

   // valid stays up between items unless send_idle inserts a random gap; wait_drained drops it at the end of a run
   task automatic send_item(input logic op, input logic [IN_SLOT_W-1:0] slot,
                            input logic [BURST_W-1:0] burst);
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_proc_slot <= slot;
      req_burst_len <= burst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      schedule_step(op, slot, burst);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sched_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_slice(input logic [CSR_IDX_W-1:0] idx, input logic [SLICE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_LEVELS) slice_len[idx] = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly short bursts over all 16 slots so processes finish and get demoted
   task automatic random_traffic(input int n);
      logic [BURST_W-1:0] b;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 9))
               0: b = '0;
               1: b = BURST_W'($urandom_range(0, 1023));
               default: b = BURST_W'($urandom_range(1, 12));
            endcase
            send_item(OP_ARRIVE, IN_SLOT_W'($urandom_range(0, 15)), b);
         end else begin
            send_item(OP_TICK, IN_SLOT_W'($urandom_range(0, 15)),
                      BURST_W'($urandom_range(0, 1023)));
         end
      end
   endtask

   task automatic test_directed();
      send_item(OP_TICK, 4'd0, '0);
      send_item(OP_ARRIVE, 4'd0, 10'd0);
      send_item(OP_ARRIVE, 4'd15, 10'd1023);
      send_item(OP_ARRIVE, 4'd15, 10'd5);
      send_item(OP_ARRIVE, 4'd0, 10'd1);
      send_item(OP_ARRIVE, 4'd7, 10'd3);
      for (int i = 0; i < 12; i++) send_item(OP_TICK, 4'hf, 10'h3ff);
      send_item(OP_ARRIVE, 4'd10, 10'd2);
      for (int i = 0; i < 4; i++) send_item(OP_TICK, 4'd5, 10'h155);
      wait_drained();
   endtask

   task automatic test_slice_settings();
      write_slice(CSR_SLICE0, 8'd0);
      write_slice(CSR_SLICE1, 8'd1);
      write_slice(CSR_SLICE2, 8'd255);
      write_slice(CSR_IDX_W'(CSR_IDX_MAX), 8'd77);
      random_traffic(300);
      wait_drained();
      write_slice(CSR_SLICE0, 8'd255);
      write_slice(CSR_SLICE1, 8'd255);
      write_slice(CSR_SLICE2, 8'd1);
      random_traffic(300);
      wait_drained();
      write_slice(CSR_SLICE0, 8'd1);
      write_slice(CSR_SLICE1, 8'd3);
      write_slice(CSR_SLICE2, 8'd5);
      random_traffic(300);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      random_traffic(40);
      hold_rsp = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_mix();
      for (int k = 0; k < 4; k++) begin
         write_slice(CSR_IDX_W'($urandom_range(0, CSR_IDX_MAX)),
                     SLICE_W'($urandom_range(0, 255)));
         random_traffic(120);
         wait_drained();
      end
      send_idle = 1'b0;
      recv_idle = 1'b0;
      random_traffic(170);
      wait_drained();
   endtask

   // response sink: random stall bursts while recv_idle is set, long hold while backpressure runs
   initial begin
      int hold_cnt;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            hold_cnt = 0;
            while (hold_cnt < 200) begin
               @(negedge clock);
               hold_cnt++;
            end
            rsp_ready <= 1'b1;
            @(negedge clock);
            while (hold_rsp) @(negedge clock);
         end else if (recv_idle && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type exp_r;
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_busy_res, rsp_run_slot, rsp_run_level, rsp_done_res,
                rsp_done_slot, rsp_turnaround, rsp_waiting};
         if (sched_expected.size() == 0) begin
            unexpected++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", got);
         end else begin
            exp_r = sched_expected.pop_front();
            ticks_seen++;
            if (got.done) done_seen++;
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p", exp_r, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      shadow_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_slice_settings();
      test_backpressure();
      test_random_mix();
      $display("covered %0d items, %0d ticks checked, %0d completions", items_sent,
               ticks_seen, done_seen);
      $display("slice extremes 0/1/255, out-of-range csr index, long output stall");
      if (mismatches == 0 && sched_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("errors %0d (unexpected %0d), left over %0d", mismatches, unexpected,
                  sched_expected.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/mlfq_pkg.sv
rtl/mlfq_front.sv
rtl/mlfq_back.sv
rtl/multilevel_feedback_queue_scheduler_unit.sv
rtl/mlfq_checker.sv
tb/tb_top.sv
